/* sv/wrrq_pkg.sv */
// Package for the weighted round-robin run queue: sizes, request and status
// codes, cell control encoding, payload structs and the slice load function.
// No dependencies.
package wrrq_pkg;

   // Queue depth and derived index widths
   localparam int MAX_TASKS = 16;
   localparam int POS_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // Field widths
   localparam int REQ_W    = 3;
   localparam int ID_W     = 16;
   localparam int WEIGHT_W = 8;
   localparam int SLICE_W  = 18;
   localparam int UNIT_W   = 10;
   localparam int SUM_W    = 12;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ENQUEUE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_DEQUEUE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TICK    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_YIELD   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PICK    = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NONE     = 2'd3;

   // Cell operations
   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_NEXT   = 3'd1;  // take neighbor's entry
   localparam logic [2:0] CELL_EXT    = 3'd2;  // take broadcast entry
   localparam logic [2:0] CELL_DEC    = 3'd3;  // count slice down
   localparam logic [2:0] CELL_RELOAD = 3'd4;  // slice from broadcast entry

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
      logic [SLICE_W-1:0]  slice;
   } entry_type;

   typedef struct packed {
      logic [2:0] op;
      logic       tok_shift;
      logic       tok_clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic [ID_W-1:0]     task_id;
      logic [WEIGHT_W-1:0] task_weight;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                picked_valid;
      logic [ID_W-1:0]     picked_task;
      logic                resched;
      logic [SUM_W-1:0]    queued_weight;
      logic [COUNT_W-1:0]  task_count;
   } rsp_payload_type;

   function automatic logic [SLICE_W-1:0] load_slice(input logic [UNIT_W-1:0]   unit,
                                                     input logic                reserved,
                                                     input logic [WEIGHT_W-1:0] weight);
      logic [SLICE_W-1:0] prod;
      prod = SLICE_W'(unit) * SLICE_W'(weight);
      return reserved ? '0 : prod;
   endfunction

endpackage

/* sv/wrrq_cell.sv */
// One queue slot: holds a task entry and a search token, shifts from its
// neighbor or loads a broadcast entry. Depends on wrrq_pkg.
module wrrq_cell
   import wrrq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cell_ctrl_type   ctrl,
   input  logic [ID_W-1:0] key,
   input  logic            tok_in,
   input  entry_type       next_entry,
   input  entry_type       ext_entry,
   output logic            tok_out,
   output entry_type       entry,
   output logic            hit
);

   entry_type entry_ff, entry_in;
   logic      tok_ff, tok_in_w;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_NEXT:   entry_in = next_entry;
         CELL_EXT:    entry_in = ext_entry;
         CELL_DEC:    entry_in.slice = entry_ff.slice - SLICE_W'(1);
         CELL_RELOAD: entry_in.slice = ext_entry.slice;
         default:     entry_in = entry_ff;
      endcase
   end

   always_comb begin
      tok_in_w = tok_ff;
      if (ctrl.tok_clear) begin
         tok_in_w = 1'b0;
      end else if (ctrl.tok_shift) begin
         tok_in_w = tok_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;
   assign entry   = entry_ff;
   assign hit     = tok_ff && (entry_ff.id == key);

endmodule

/* sv/weighted_round_robin_run_queue_unit.sv */
// Weighted round-robin run queue, top level: request sequencer, row of
// wrrq_cell slots, result register and configuration registers.
// Depends on wrrq_pkg and wrrq_cell.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data) carries one request per
//    transaction: enqueue, dequeue, tick, yield or pick.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data) returns exactly one result
//    transaction per request, in order.
//  - csr port (APB style) holds slice_unit at byte 0 and reserved_queue at
//    byte 4; write only while the block is idle. pready is tied high.
//  Sequencing: enqueue, pick and unused codes pass through the execute and
//  output states to the output register. Dequeue, tick and yield first pass a
//  search token down the cell row, one cell per cycle, before those states; on
//  an empty queue they go straight to the output state with not-found status.
//  One request is in flight at a time: the next is accepted only once its
//  result has moved to the output register.
//  A result waiting under rsp_stall sits in the output register while the
//  next request is taken and worked; only a second finished result waits.
//  Reset (synchronous) empties the queue, restores slice_unit to 10 and
//  reserved_queue to 0, and drops any pending result.
module weighted_round_robin_run_queue_unit
   import wrrq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   // result channel
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   // configuration port
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;  // token walking the cell row
   localparam logic [1:0] S_EXEC = 2'd2;  // apply the update to the cells
   localparam logic [1:0] S_OUT  = 2'd3;  // hand result to output register

   logic [1:0]       state_ff, state_in;
   req_payload_type  req_ff, req_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   rsp_payload_type  res_ff, res_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [UNIT_W-1:0] unit_ff;
   logic             reserved_ff;

   // cell row
   cell_ctrl_type ctrl [MAX_TASKS];
   entry_type     cell_entry [MAX_TASKS];
   entry_type     next_entry [MAX_TASKS];
   logic          tok_chain [MAX_TASKS+1];
   logic [MAX_TASKS-1:0] hit_vec;

   logic             req_accept;
   logic             is_search_req;
   logic             tok_start;
   logic             tok_shift;
   logic             tok_clear;
   logic             found;
   logic             scan_last;
   logic             slot_free;
   entry_type        sel_entry;
   entry_type        ext_entry;
   logic [WEIGHT_W-1:0] mul_weight;
   logic [SLICE_W-1:0]  new_slice;
   logic             is_move;
   logic             queue_full;
   logic             csr_write;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign is_search_req = (req_data.req_type == REQ_DEQUEUE) ||
                          (req_data.req_type == REQ_TICK)    ||
                          (req_data.req_type == REQ_YIELD);

   // token enters cell 0 on accept of a search request on a non-empty queue
   assign tok_start = req_accept && is_search_req && (count_ff != '0);
   assign found     = |hit_vec;
   assign scan_last = (CNT_W'(pos_ff) + CNT_W'(1)) == count_ff;
   assign tok_shift = tok_start || ((state_ff == S_SCAN) && !found && !scan_last);
   assign tok_clear = (state_ff == S_EXEC) || ((state_ff == S_SCAN) && !found && scan_last);

   assign sel_entry  = cell_entry[pos_ff];
   assign queue_full = (count_ff == CNT_W'(MAX_TASKS));
   assign is_move    = (req_ff.req_type == REQ_YIELD) ||
                       ((req_ff.req_type == REQ_TICK) && (sel_entry.slice == '0));

   // single shared slice multiplier
   always_comb begin
      mul_weight = sel_entry.weight;
      if (req_ff.req_type == REQ_ENQUEUE) begin
         mul_weight = req_ff.task_weight;
      end else if (req_ff.req_type == REQ_PICK) begin
         mul_weight = cell_entry[0].weight;
      end
   end

   assign new_slice = load_slice(unit_ff, reserved_ff, mul_weight);

   // broadcast entry: new task on enqueue, relocated task on a move,
   // reloaded slice for the head on pick
   always_comb begin
      ext_entry = sel_entry;
      if (req_ff.req_type == REQ_ENQUEUE) begin
         ext_entry.id     = req_ff.task_id;
         ext_entry.weight = req_ff.task_weight;
         ext_entry.slice  = new_slice;
      end else if ((req_ff.req_type == REQ_TICK) || (req_ff.req_type == REQ_PICK)) begin
         ext_entry.slice = new_slice;
      end
   end

   // per-cell control, each cell decides from its own index
   always_comb begin
      for (int j = 0; j < MAX_TASKS; j++) begin
         ctrl[j].tok_shift = tok_shift;
         ctrl[j].tok_clear = tok_clear;
         ctrl[j].op        = CELL_HOLD;
         if (state_ff == S_EXEC) begin
            case (req_ff.req_type)
               REQ_ENQUEUE: begin
                  if (!queue_full && (CNT_W'(j) == count_ff)) begin
                     ctrl[j].op = CELL_EXT;
                  end
               end
               REQ_DEQUEUE: begin
                  if ((CNT_W'(j) >= CNT_W'(pos_ff)) && (CNT_W'(j + 1) < count_ff)) begin
                     ctrl[j].op = CELL_NEXT;
                  end
               end
               REQ_TICK, REQ_YIELD: begin
                  if (is_move) begin
                     if ((CNT_W'(j) >= CNT_W'(pos_ff)) && (CNT_W'(j + 1) < count_ff)) begin
                        ctrl[j].op = CELL_NEXT;
                     end else if (CNT_W'(j + 1) == count_ff) begin
                        ctrl[j].op = CELL_EXT;
                     end
                  end else if (POS_W'(j) == pos_ff) begin
                     ctrl[j].op = CELL_DEC;
                  end
               end
               REQ_PICK: begin
                  if ((j == 0) && (count_ff != '0) && !reserved_ff) begin
                     ctrl[j].op = CELL_RELOAD;
                  end
               end
               default: ctrl[j].op = CELL_HOLD;
            endcase
         end
      end
   end

   assign tok_chain[0] = tok_start;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      if (g == MAX_TASKS - 1) begin : g_tail
         assign next_entry[g] = '0;
      end else begin : g_mid
         assign next_entry[g] = cell_entry[g+1];
      end

      wrrq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl[g]),
         .key        (req_ff.task_id),
         .tok_in     (tok_chain[g]),
         .next_entry (next_entry[g]),
         .ext_entry  (ext_entry),
         .tok_out    (tok_chain[g+1]),
         .entry      (cell_entry[g]),
         .hit        (hit_vec[g])
      );
   end

   // sequencer
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in               = req_data;
               pos_in               = '0;
               res_in.status        = STAT_OK;
               res_in.picked_valid  = 1'b0;
               res_in.picked_task   = '0;
               res_in.resched       = 1'b0;
               res_in.queued_weight = sum_ff;
               res_in.task_count    = COUNT_W'(count_ff);
               if (is_search_req) begin
                  if (count_ff == '0) begin
                     res_in.status = STAT_NOTFOUND;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               state_in = S_EXEC;
            end else if (scan_last) begin
               res_in.status = STAT_NOTFOUND;
               state_in      = S_OUT;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
         S_EXEC: begin
            case (req_ff.req_type)
               REQ_ENQUEUE: begin
                  if (queue_full) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     sum_in   = sum_ff + SUM_W'(req_ff.task_weight);
                  end
               end
               REQ_DEQUEUE: begin
                  count_in = count_ff - CNT_W'(1);
                  sum_in   = sum_ff - SUM_W'(sel_entry.weight);
               end
               REQ_TICK: begin
                  res_in.resched = (sel_entry.slice == '0);
               end
               REQ_PICK: begin
                  if ((count_ff == '0) || reserved_ff) begin
                     res_in.status = STAT_NONE;
                  end else begin
                     res_in.picked_valid = 1'b1;
                     res_in.picked_task  = cell_entry[0].id;
                  end
               end
               default: res_in.status = STAT_OK;
            endcase
            res_in.queued_weight = sum_in;
            res_in.task_count    = COUNT_W'(count_in);
            state_in             = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_OUT) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pos_ff      <= pos_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration registers
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff     <= UNIT_W'(10);
         reserved_ff <= 1'b0;
      end else if (csr_write) begin
         if (csr_paddr[2]) begin
            reserved_ff <= csr_pwdata[0];
         end else begin
            unit_ff <= csr_pwdata[UNIT_W-1:0];
         end
      end
   end

   assign csr_prdata = csr_paddr[2] ? {31'b0, reserved_ff} : {{(32 - UNIT_W){1'b0}}, unit_ff};

endmodule

/* sv/wrrq_checker.sv */
// Port-level checker for the run queue top level, attached by bind.
// Depends on wrrq_pkg and weighted_round_robin_run_queue_unit.
module wrrq_checker
   import wrrq_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data,
   input logic            csr_psel,
   input logic            csr_penable,
   input logic            csr_pwrite,
   input logic [2:0]      csr_paddr,
   input logic [31:0]     csr_pwdata,
   input logic [31:0]     csr_prdata,
   input logic            csr_pready
);

   // a stalled result transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // a picked task only comes with ok status and no reschedule
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.picked_valid) |->
         ((rsp_data.status == STAT_OK) && !rsp_data.resched))
      else $error("picked task with bad status or resched");

   // occupancy never exceeds the queue depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.task_count <= COUNT_W'(MAX_TASKS)))
      else $error("task_count above queue depth");

   // an empty queue carries no weight
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.task_count == '0)) |-> (rsp_data.queued_weight == '0))
      else $error("weight left on empty queue");

   // only one request in flight: accept is followed by stall
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction accepted while busy");

endmodule

bind weighted_round_robin_run_queue_unit wrrq_checker u_wrrq_checker (.*);

/* test/tb_weighted_round_robin_run_queue_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for weighted_round_robin_run_queue_unit: random request
// traffic with an in-bench run queue predictor. Depends on wrrq_pkg and the unit.
module tb_weighted_round_robin_run_queue_unit;
   import wrrq_pkg::*;

   // CSR byte addresses, one 32-bit register per word
   localparam logic [2:0] CSR_ADDR_SLICE_UNIT = 3'd0;
   localparam logic [2:0] CSR_ADDR_RESERVED   = 3'd4;

   // request codes the unit treats as no-ops
   localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

   localparam logic [UNIT_W-1:0] RESET_SLICE_UNIT = 10'd10;

   // end-of-run settle: worst-case token walk plus margin
   localparam int SETTLE_CYCLES   = MAX_TASKS + 8;
   // cycles with no transaction on any port before the run is abandoned
   localparam int WATCHDOG_LIMIT  = 4000;
   // receiver long hold-off: length and the result counts that trigger it
   localparam int LONG_HOLD       = 80;
   localparam int HOLD_FIRST_AT   = 350;
   localparam int HOLD_SPACING    = 670;
   localparam int PHASE_ITEMS     = 134;
   localparam int PRINT_CAP       = 200;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_data    = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_psel    = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite  = 1'b0;
   logic [2:0]      csr_paddr   = '0;
   logic [31:0]     csr_pwdata  = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   weighted_round_robin_run_queue_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Run queue predictor: ordered task list plus the two config registers.
   // Only entries below rq_count are ever read.
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]     rq_ids     [MAX_TASKS];
   logic [WEIGHT_W-1:0] rq_weights [MAX_TASKS];
   logic [SLICE_W-1:0]  rq_slices  [MAX_TASKS];
   int                  rq_count       = 0;
   logic [SUM_W-1:0]    rq_weight_sum  = '0;
   logic [UNIT_W-1:0]   cfg_slice_unit = RESET_SLICE_UNIT;
   logic                cfg_reserved   = 1'b0;

   function automatic logic [SLICE_W-1:0] fresh_slice(input logic [WEIGHT_W-1:0] w);
      logic [SLICE_W-1:0] grant;
      grant = SLICE_W'(cfg_slice_unit) * SLICE_W'(w);  // 1023 * 255 fits 18 bits
      if (cfg_reserved)
         grant = '0;
      return grant;
   endfunction

   // first match from the head wins (duplicate ids allowed)
   function automatic int locate_task(input logic [ID_W-1:0] id);
      for (int i = 0; i < rq_count; i++)
         if (rq_ids[i] == id)
            return i;
      return rq_count;
   endfunction

   function automatic void rotate_to_tail(input int pos);
      logic [ID_W-1:0]     id_keep;
      logic [WEIGHT_W-1:0] w_keep;
      logic [SLICE_W-1:0]  s_keep;
      id_keep = rq_ids[pos];
      w_keep  = rq_weights[pos];
      s_keep  = rq_slices[pos];
      for (int i = pos; i < rq_count - 1; i++) begin
         rq_ids[i]     = rq_ids[i+1];
         rq_weights[i] = rq_weights[i+1];
         rq_slices[i]  = rq_slices[i+1];
      end
      rq_ids[rq_count-1]     = id_keep;
      rq_weights[rq_count-1] = w_keep;
      rq_slices[rq_count-1]  = s_keep;
   endfunction

   // Applies one request to the predicted queue, returns the predicted result.
   function automatic rsp_payload_type schedule_request(input req_payload_type r);
      rsp_payload_type o;
      int              pos;
      o   = '0;
      pos = locate_task(r.task_id);
      case (r.req_type)
         REQ_ENQUEUE: begin
            if (rq_count >= MAX_TASKS) begin
               o.status = STAT_FULL;
            end else begin
               rq_ids[rq_count]     = r.task_id;
               rq_weights[rq_count] = r.task_weight;
               rq_slices[rq_count]  = fresh_slice(r.task_weight);
               rq_count++;
               rq_weight_sum = rq_weight_sum + SUM_W'(r.task_weight);
            end
         end
         REQ_DEQUEUE: begin
            if (pos >= rq_count) begin
               o.status = STAT_NOTFOUND;
            end else begin
               rq_weight_sum = rq_weight_sum - SUM_W'(rq_weights[pos]);
               for (int i = pos; i < rq_count - 1; i++) begin
                  rq_ids[i]     = rq_ids[i+1];
                  rq_weights[i] = rq_weights[i+1];
                  rq_slices[i]  = rq_slices[i+1];
               end
               rq_count--;
            end
         end
         REQ_TICK: begin
            if (pos >= rq_count) begin
               o.status = STAT_NOTFOUND;
            end else if (rq_slices[pos] == '0) begin
               // slice exhausted: reload, go to the back, ask for resched
               rq_slices[pos] = fresh_slice(rq_weights[pos]);
               if (rq_count > 1)
                  rotate_to_tail(pos);
               o.resched = 1'b1;
            end else begin
               rq_slices[pos] = rq_slices[pos] - SLICE_W'(1);
            end
         end
         REQ_YIELD: begin
            if (pos >= rq_count)
               o.status = STAT_NOTFOUND;
            else
               rotate_to_tail(pos);
         end
         REQ_PICK: begin
            if (rq_count == 0 || cfg_reserved) begin
               o.status = STAT_NONE;
            end else begin
               rq_slices[0]   = fresh_slice(rq_weights[0]);
               o.picked_valid = 1'b1;
               o.picked_task  = rq_ids[0];
            end
         end
         default: ;  // spare codes: no effect, status ok
      endcase
      o.queued_weight = rq_weight_sum;
      o.task_count    = COUNT_W'(rq_count);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------
   req_payload_type sched_requests[$];   // requests waiting for the driver
   rsp_payload_type sched_outcomes[$];   // predicted results, oldest first
   int issued_total   = 0;               // requests handed to the driver
   int result_total   = 0;               // result transactions seen
   int error_total    = 0;
   int idle_cycles    = 0;
   logic req_taken    = 1'b0;            // request accepted at last rising edge
   int settings_used  = 1;

   // coverage tallies, taken from the predicted results
   int n_picked = 0, n_no_pick = 0, n_resched = 0, n_full = 0;
   int n_missing = 0, n_spare = 0, n_holds = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_total < PRINT_CAP)
         $display("[%0t] mismatch on %s at result %0d: got %0h, want %0h",
                  $realtime, what, result_total, got, want);
      error_total++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps in between.
   // A stalled transaction holds its payload until accepted.
   // ---------------------------------------------------------------------
   int send_burst_left = 0;
   int send_gap_left   = 0;

   always @(negedge clock) begin : req_driver
      logic            offer;
      req_payload_type nxt;
      offer = 1'b0;
      nxt   = req_data;
      if (reset) begin
         offer = 1'b0;
      end else if (req_valid && !req_taken) begin
         offer = 1'b1;  // still waiting on the unit, keep it steady
      end else if (send_gap_left > 0) begin
         send_gap_left--;
      end else if (sched_requests.size() > 0) begin
         nxt   = sched_requests.pop_front();
         offer = 1'b1;
         if (send_burst_left > 0) begin
            send_burst_left--;
         end else begin
            // plan the next burst; a quarter of the time no gap at all
            send_burst_left = $urandom_range(1, 40);
            send_gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end
      end
      req_valid <= offer;
      req_data  <= nxt;
   end

   // ---------------------------------------------------------------------
   // Result receiver: alternating runs of stall and flow, plus a long
   // hold-off at set result counts so the unit backs up into req_stall.
   // ---------------------------------------------------------------------
   int   stall_run_left = 0;
   logic stall_run_on   = 1'b0;
   int   hold_left      = 0;
   int   next_hold_at   = HOLD_FIRST_AT;

   always @(negedge clock) begin : rsp_receiver
      logic stall_now;
      stall_now = 1'b0;
      if (!reset) begin
         if (result_total >= next_hold_at) begin
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + HOLD_SPACING;
            n_holds++;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
         end else begin
            if (stall_run_left == 0) begin
               stall_run_on   = ($urandom_range(0, 2) == 0);
               stall_run_left = stall_run_on ? $urandom_range(1, 6) : $urandom_range(1, 25);
            end
            stall_run_left--;
            stall_now = stall_run_on;
         end
      end
      rsp_stall <= stall_now;
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on every accepted request transaction, checks every
   // accepted result transaction field by field, and runs the watchdog.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : observer
      rsp_payload_type want;
      logic            busy;
      busy = 1'b0;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            want = schedule_request(req_data);
            sched_outcomes.push_back(want);
            busy = 1'b1;
            if (want.picked_valid)                       n_picked++;
            if (want.status == STAT_NONE)                n_no_pick++;
            if (want.resched)                            n_resched++;
            if (want.status == STAT_FULL)                n_full++;
            if (want.status == STAT_NOTFOUND)            n_missing++;
            if (req_data.req_type >= REQ_SPARE_FIRST)    n_spare++;
         end
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            if (sched_outcomes.size() == 0) begin
               report_mismatch("unrequested result", 32'(rsp_data.picked_task), '0);
            end else begin
               want = sched_outcomes.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.picked_valid !== want.picked_valid)
                  report_mismatch("picked_valid", 32'(rsp_data.picked_valid),
                                  32'(want.picked_valid));
               if (rsp_data.picked_task !== want.picked_task)
                  report_mismatch("picked_task", 32'(rsp_data.picked_task),
                                  32'(want.picked_task));
               if (rsp_data.resched !== want.resched)
                  report_mismatch("resched", 32'(rsp_data.resched), 32'(want.resched));
               if (rsp_data.queued_weight !== want.queued_weight)
                  report_mismatch("queued_weight", 32'(rsp_data.queued_weight),
                                  32'(want.queued_weight));
               if (rsp_data.task_count !== want.task_count)
                  report_mismatch("task_count", 32'(rsp_data.task_count),
                                  32'(want.task_count));
            end
            result_total++;
         end
         if (csr_psel && csr_penable)
            busy = 1'b1;
         idle_cycles = busy ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d of %0d results seen",
                     WATCHDOG_LIMIT, result_total, issued_total);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // CSR access. Setup then access phase, driven on falling edges.
   // ---------------------------------------------------------------------
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_config();
      logic [31:0] rd;
      csr_access(1'b0, CSR_ADDR_SLICE_UNIT, '0, rd);
      if (rd !== 32'(cfg_slice_unit))
         report_mismatch("slice_unit readback", rd, 32'(cfg_slice_unit));
      csr_access(1'b0, CSR_ADDR_RESERVED, '0, rd);
      if (rd !== 32'(cfg_reserved))
         report_mismatch("reserved_queue readback", rd, 32'(cfg_reserved));
   endtask

   // only called with the unit idle (all results back)
   task automatic set_config(input logic [UNIT_W-1:0] unit, input logic reserved);
      logic [31:0] unused_rd;
      csr_access(1'b1, CSR_ADDR_SLICE_UNIT, 32'(unit), unused_rd);
      csr_access(1'b1, CSR_ADDR_RESERVED, 32'(reserved), unused_rd);
      cfg_slice_unit = unit;
      cfg_reserved   = reserved;
      settings_used++;
      check_config();
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers. Pushes happen just after a rising edge so they never
   // share a time step with the driver's pop.
   // ---------------------------------------------------------------------
   logic [ID_W-1:0] id_pool [8];

   task automatic add_request(input logic [REQ_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [WEIGHT_W-1:0] w);
      req_payload_type item;
      item.req_type    = op;
      item.task_id     = id;
      item.task_weight = w;
      sched_requests.push_back(item);
      issued_total++;
   endtask

   function automatic logic [WEIGHT_W-1:0] random_weight();
      // mostly tiny weights so slices actually run out under ticks
      if ($urandom_range(0, 9) < 7)
         return WEIGHT_W'($urandom_range(0, 3));
      return WEIGHT_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [ID_W-1:0] random_id();
      if ($urandom_range(0, 9) == 0)
         return ID_W'($urandom_range(0, 16'hFFFF));  // almost surely absent
      return id_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [REQ_W-1:0] REQ_TYPE_SPARE();
      return REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
   endfunction

   // Mostly well-formed scheduler traffic over a small id pool; enq_pct sets
   // how hard the queue is pushed toward full.
   task automatic queue_random_phase(input int n, input int enq_pct);
      int              phase_end;
      int              roll;
      int              reps;
      logic [ID_W-1:0] id;
      @(posedge clock);
      phase_end = issued_total + n;
      while (issued_total < phase_end) begin
         roll = $urandom_range(0, 99);
         id   = random_id();
         if (roll < enq_pct) begin
            add_request(REQ_ENQUEUE, id_pool[$urandom_range(0, 7)], random_weight());
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
               // run of ticks on one task, as a running task would see
               reps = $urandom_range(1, 5);
               repeat (reps) add_request(REQ_TICK, id, WEIGHT_W'($urandom));
            end else if (roll < 55) begin
               add_request(REQ_DEQUEUE, id, WEIGHT_W'($urandom));
            end else if (roll < 70) begin
               add_request(REQ_YIELD, id, WEIGHT_W'($urandom));
            end else if (roll < 95) begin
               add_request(REQ_PICK, id, WEIGHT_W'($urandom));
            end else begin
               add_request(REQ_TYPE_SPARE(), id, WEIGHT_W'($urandom));
            end
         end
      end
   endtask

   // sender stands still until every result is back
   task automatic wait_drained();
      while (result_total != issued_total)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      id_pool[2] = 16'h5A5A;
      id_pool[3] = 16'hA5A5;
      for (int i = 4; i < 8; i++)
         id_pool[i] = ID_W'($urandom_range(1, 16'hFFFE));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values of the registers
      check_config();

      // Directed part at reset settings (unit 10, not reserved)
      @(posedge clock);
      add_request(REQ_PICK,    16'h0000, 8'h00);   // empty pick
      add_request(REQ_DEQUEUE, 16'h0001, 8'hFF);   // unknown ids
      add_request(REQ_TICK,    16'hFFFF, 8'h00);
      add_request(REQ_YIELD,   16'h0000, 8'h00);
      add_request(REQ_SPARE_FIRST,      16'hFFFF, 8'hFF);
      add_request(REQ_W'(REQ_SPARE_FIRST + 3'd1), 16'h0000, 8'h00);
      add_request(REQ_SPARE_LAST,       16'hFFFF, 8'hFF);
      add_request(REQ_ENQUEUE, 16'h0000, 8'hFF);   // max weight
      add_request(REQ_ENQUEUE, 16'hFFFF, 8'h00);   // zero weight, zero slice
      add_request(REQ_ENQUEUE, 16'h1234, 8'h01);
      add_request(REQ_ENQUEUE, 16'h0000, 8'h07);   // duplicate id
      add_request(REQ_TICK,    16'hFFFF, 8'h00);   // exhausts at once -> resched
      add_request(REQ_TICK,    16'h1234, 8'h00);   // plain countdown
      add_request(REQ_YIELD,   16'h0000, 8'h00);   // head-most duplicate moves
      add_request(REQ_PICK,    16'h5555, 8'h00);
      add_request(REQ_DEQUEUE, 16'h0000, 8'h00);
      add_request(REQ_DEQUEUE, 16'h1234, 8'h00);
      wait_drained();

      // Random part: one setting per phase, extremes included, queue state
      // carried across phases.
      queue_random_phase(PHASE_ITEMS, 30);
      wait_drained();
      set_config(10'd1, 1'b0);
      queue_random_phase(PHASE_ITEMS, 30);
      wait_drained();
      set_config(10'd0, 1'b0);                     // zero unit
      queue_random_phase(PHASE_ITEMS, 25);
      wait_drained();
      set_config(10'd1023, 1'b0);                  // largest unit
      queue_random_phase(PHASE_ITEMS, 35);
      wait_drained();
      set_config(10'd2, 1'b1);                     // reserved queue
      queue_random_phase(PHASE_ITEMS, 30);
      wait_drained();
      set_config(10'd3, 1'b0);
      queue_random_phase(PHASE_ITEMS, 60);         // drives the queue to full
      wait_drained();
      set_config(10'd1, 1'b0);
      queue_random_phase(PHASE_ITEMS, 15);         // drains it again
      wait_drained();
      set_config(UNIT_W'($urandom_range(1, 1000)), 1'b0);
      queue_random_phase(PHASE_ITEMS, 30);
      wait_drained();
      set_config(10'd1, 1'b1);
      queue_random_phase(PHASE_ITEMS, 25);
      wait_drained();
      set_config(10'd2, 1'b0);
      queue_random_phase(PHASE_ITEMS, 30);
      wait_drained();

      // let any stray result show up before closing
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sched_outcomes.size() != 0)
         report_mismatch("results never returned", sched_outcomes.size(), 0);

      $display("Covered %0d requests under %0d queue settings: %0d picks, %0d empty or reserved",
               issued_total, settings_used, n_picked, n_no_pick);
      $display("picks, %0d reschedules, %0d full rejects, %0d unknown ids, %0d spare codes, %0d holds",
               n_resched, n_full, n_missing, n_spare, n_holds);
      if (error_total == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
